// ===== hw/rtl/tpa_pkg.sv =====
package tpa_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 256;
  localparam int POOL_COUNT = 2;
  localparam int PTR_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int SEL_W      = $clog2(POOL_COUNT);
  localparam int MEM_AW     = SEL_W + PTR_W;

  // Field widths fixed by the interface
  localparam int ID_W     = 16;
  localparam int PCOUNT_W = 9;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_POOL0_BASE  = 2'd0,
    REG_POOL0_COUNT = 2'd1,
    REG_POOL1_BASE  = 2'd2,
    REG_POOL1_COUNT = 2'd3
  } reg_idx_t;

  // Request kinds
  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_FREE    = 2'd1,
    K_QUERY   = 2'd2,
    K_RESTART = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FOREIGN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the request
    logic commit;  // finish a request that needs no memory read
    logic mem_rd;  // read the recycle entry at the head
    logic finish;  // finish an allocate from the recycle list
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read;
  } dp_stat_t;

  // Effective pool size: counts above the depth act as the depth
  function automatic logic [CNT_W-1:0] pool_size(input logic [PCOUNT_W-1:0] cnt);
    logic [CNT_W-1:0] sz;
    if (32'(cnt) > POOL_DEPTH) sz = CNT_W'(POOL_DEPTH);
    else sz = CNT_W'(cnt);
    return sz;
  endfunction

  // Range test without wrap: base <= id < base + size
  function automatic logic in_range(input logic [ID_W-1:0] id,
                                    input logic [ID_W-1:0] base,
                                    input logic [CNT_W-1:0] sz);
    logic [ID_W:0] lim;
    lim = {1'b0, base} + (ID_W+1)'(sz);
    return (id >= base) && ({1'b0, id} < lim);
  endfunction

endpackage

// ===== hw/rtl/tpa_ctrl.sv =====
module tpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tpa_pkg::dp_stat_t    stat,
  output tpa_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);
  import tpa_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.need_read ? S_READ : S_IDLE;
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_EXEC: begin
        cmd.mem_rd = stat.need_read;
        cmd.commit = !stat.need_read;
      end
      S_READ: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // A memory read always leads to the read state
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |=> state_r == S_READ)
    else $error("memory read not followed by read state");

  // Only one request in flight: latch happens only when idle
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> !busy)
    else $error("request latched while busy");

  // Every latched request moves on from execute to idle or the read state
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> ##1 (state_r == S_IDLE || state_r == S_READ))
    else $error("request did not progress");

endmodule

// ===== hw/rtl/tpa_datapath.sv =====
module tpa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpa_pkg::ctrl_cmd_t            cmd,
  output tpa_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tpa_pkg::CFG_DW-1:0]    cfg_data,
  input  logic [1:0]                    in_kind,
  input  logic signed [1:0]             in_pool,
  input  logic [tpa_pkg::ID_W-1:0]      in_id_value,
  output logic                          out_valid,
  output logic [tpa_pkg::ID_W-1:0]      out_id_result,
  output logic                          out_owned,
  output logic [1:0]                    out_status
);
  import tpa_pkg::*;

  // Configuration registers
  logic [ID_W-1:0]     base_r  [POOL_COUNT];
  logic [PCOUNT_W-1:0] count_r [POOL_COUNT];

  // Latched request
  kind_t           kind_r;
  logic [1:0]      pool_r;
  logic [ID_W-1:0] id_r;

  // Per-pool allocator state
  logic [CNT_W-1:0] fresh_r [POOL_COUNT];
  logic [PTR_W-1:0] head_r  [POOL_COUNT];
  logic [PTR_W-1:0] tail_r  [POOL_COUNT];
  logic [CNT_W-1:0] fill_r  [POOL_COUNT];

  // Recycle store, both pools in one memory
  logic [PTR_W-1:0] mem [2**MEM_AW];
  logic [PTR_W-1:0] rd_data_r;

  // Result registers
  logic            out_valid_r;
  logic [ID_W-1:0] res_r, res_nxt;
  logic            owned_r, owned_nxt;
  status_t         status_r, status_nxt;

  logic [CNT_W-1:0] size0, size1;
  logic             alloc_ok, alloc_p, fresh_avail;
  logic             hit0, hit1, hit, free_p, full;
  logic [PTR_W-1:0] free_local;
  logic             do_push, do_fresh, do_pop;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0]  <= '0;
      base_r[1]  <= '0;
      count_r[0] <= '0;
      count_r[1] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_POOL0_BASE:  base_r[0]  <= cfg_data;
        REG_POOL0_COUNT: count_r[0] <= cfg_data[PCOUNT_W-1:0];
        REG_POOL1_BASE:  base_r[1]  <= cfg_data;
        REG_POOL1_COUNT: count_r[1] <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= kind_t'(in_kind);
      pool_r <= in_pool;
      id_r   <= in_id_value;
    end
  end

  // Decode
  assign size0       = pool_size(count_r[0]);
  assign size1       = pool_size(count_r[1]);
  assign alloc_ok    = !pool_r[1];
  assign alloc_p     = pool_r[0];
  assign fresh_avail = fresh_r[alloc_p] < (alloc_p ? size1 : size0);
  assign hit0        = in_range(id_r, base_r[0], size0);
  assign hit1        = in_range(id_r, base_r[1], size1);
  assign hit         = hit0 | hit1;
  assign free_p      = !hit0;
  assign full        = fill_r[free_p] == CNT_W'(POOL_DEPTH);
  assign free_local  = PTR_W'(id_r - base_r[free_p]);

  assign stat.need_read = (kind_r == K_ALLOC) && alloc_ok && !fresh_avail &&
                          (fill_r[alloc_p] != '0);

  assign do_fresh = cmd.commit && (kind_r == K_ALLOC) && alloc_ok && fresh_avail;
  assign do_push  = cmd.commit && (kind_r == K_FREE) && hit && !full;
  assign do_pop   = cmd.finish;

  // Result values
  always_comb begin
    res_nxt    = '0;
    owned_nxt  = 1'b0;
    status_nxt = ST_OK;
    if (cmd.finish) begin
      res_nxt = base_r[alloc_p] + ID_W'(rd_data_r);
    end else begin
      case (kind_r)
        K_ALLOC: begin
          if (alloc_ok) begin
            if (fresh_avail) res_nxt = base_r[alloc_p] + ID_W'(fresh_r[alloc_p]);
            else status_nxt = ST_EMPTY;
          end
        end
        K_FREE: begin
          if (!hit) begin
            status_nxt = ST_FOREIGN;
          end else begin
            owned_nxt = 1'b1;
            if (full) status_nxt = ST_FULL;
          end
        end
        K_QUERY: owned_nxt = hit;
        K_RESTART: ;
        default: ;
      endcase
    end
  end

  // Counters and FIFO pointers
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.commit && kind_r == K_RESTART)) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        fresh_r[p] <= '0;
        head_r[p]  <= '0;
        tail_r[p]  <= '0;
        fill_r[p]  <= '0;
      end
    end else begin
      if (do_fresh) fresh_r[alloc_p] <= fresh_r[alloc_p] + 1'b1;
      if (do_push) begin
        tail_r[free_p] <= tail_r[free_p] + 1'b1;
        fill_r[free_p] <= fill_r[free_p] + 1'b1;
      end
      if (do_pop) begin
        head_r[alloc_p] <= head_r[alloc_p] + 1'b1;
        fill_r[alloc_p] <= fill_r[alloc_p] - 1'b1;
      end
    end
  end

  // Recycle memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_push) mem[{free_p, tail_r[free_p]}] <= free_local;
    if (cmd.mem_rd) rd_data_r <= mem[{alloc_p, head_r[alloc_p]}];
  end

  // Result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.commit | cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit | cmd.finish) begin
      res_r    <= res_nxt;
      owned_r  <= owned_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_id_result = res_r;
  assign out_owned     = owned_r;
  assign out_status    = status_r;

  // Results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

  // Fill count never exceeds the list depth
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= CNT_W'(POOL_DEPTH) && fill_r[1] <= CNT_W'(POOL_DEPTH))
    else $error("recycle fill overflow");

  // Pointer distance matches the fill count
  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(tail_r[0] - head_r[0]) == fill_r[0][PTR_W-1:0]) &&
    (PTR_W'(tail_r[1] - head_r[1]) == fill_r[1][PTR_W-1:0]))
    else $error("recycle pointers disagree with fill");

  // A read is issued only for a non-empty list
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |-> fill_r[alloc_p] != '0)
    else $error("read from empty recycle list");

endmodule

// ===== hw/rtl/two_pool_id_free_list_allocator_core.sv =====
// Two-pool identifier allocator. A request is taken when start is high and
// busy is low; its single result appears on the out_ ports for one cycle with
// out_valid high, and the receiver cannot stall it. Every request but an
// allocate served from the recycle list passes through the execute state, with
// the result strobe in the following cycle while the next request can be taken.
// An allocate served from the recycle list adds the read state, for the
// registered read of the recycle memory, which needs no clearing after reset
// or restart. Configuration is written through cfg_we/cfg_index/cfg_data, by
// the user only while no request is in flight; the block does not enforce it.
module two_pool_id_free_list_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tpa_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic signed [1:0]             in_pool,
  input  logic [tpa_pkg::ID_W-1:0]      in_id_value,
  output logic                          out_valid,
  output logic [tpa_pkg::ID_W-1:0]      out_id_result,
  output logic                          out_owned,
  output logic [1:0]                    out_status
);
  import tpa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  tpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Pools, recycle lists and result registers
  tpa_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_kind),
    .in_pool       (in_pool),
    .in_id_value   (in_id_value),
    .out_valid     (out_valid),
    .out_id_result (out_id_result),
    .out_owned     (out_owned),
    .out_status    (out_status)
  );

endmodule

// ===== verif/id_pool_monitor.sv =====
module id_pool_monitor
  import tpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_kind,
  input  logic signed [1:0]   in_pool,
  input  logic [ID_W-1:0]     in_id_value,
  input  logic                out_valid,
  input  logic [ID_W-1:0]     out_id_result,
  input  logic                out_owned,
  input  logic [1:0]          out_status,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [ID_W-1:0] id_result;
    logic            owned;
    status_t         status;
  } reply_t;

  // Pool setup as last written
  logic [ID_W-1:0]     base_q  [POOL_COUNT];
  logic [PCOUNT_W-1:0] count_q [POOL_COUNT];

  // Per-pool fresh counter and free list
  logic [CNT_W-1:0] fresh_next [POOL_COUNT];
  logic [PTR_W-1:0] rec_store  [POOL_COUNT][POOL_DEPTH];
  logic [PTR_W-1:0] rec_head   [POOL_COUNT];
  logic [PTR_W-1:0] rec_tail   [POOL_COUNT];
  logic [CNT_W-1:0] rec_fill   [POOL_COUNT];

  reply_t replies_due[$];
  int     mismatches = 0;

  // Counts above the depth behave as the depth
  function automatic logic [CNT_W-1:0] usable_size(int p);
    if (count_q[p] > POOL_DEPTH) return CNT_W'(POOL_DEPTH);
    return CNT_W'(count_q[p]);
  endfunction

  // Range check done at 17 bits so base + size cannot wrap
  function automatic logic holds(int p, logic [ID_W-1:0] id);
    logic [ID_W:0] lim;
    lim = {1'b0, base_q[p]} + (ID_W+1)'(usable_size(p));
    return (id >= base_q[p]) && ({1'b0, id} < lim);
  endfunction

  function automatic void rewind();
    for (int p = 0; p < POOL_COUNT; p++) begin
      fresh_next[p] = '0;
      rec_head[p]   = '0;
      rec_tail[p]   = '0;
      rec_fill[p]   = '0;
    end
  endfunction

  // Apply one request to the shadow pools and return its reply
  function automatic reply_t serve_request(logic [1:0] kind, logic signed [1:0] psel,
                                           logic [ID_W-1:0] id);
    reply_t r;
    int     p;
    r.id_result = '0;
    r.owned     = 1'b0;
    r.status    = ST_OK;
    case (kind_t'(kind))
      K_ALLOC: begin
        // negative pool codes mean no pool: zero reply, no change
        if (psel >= 0) begin
          p = int'(psel);
          if (fresh_next[p] < usable_size(p)) begin
            r.id_result   = base_q[p] + ID_W'(fresh_next[p]);
            fresh_next[p] = fresh_next[p] + 1'b1;
          end else if (rec_fill[p] != 0) begin
            r.id_result = base_q[p] + ID_W'(rec_store[p][rec_head[p]]);
            rec_head[p] = rec_head[p] + 1'b1;
            rec_fill[p] = rec_fill[p] - 1'b1;
          end else begin
            r.status = ST_EMPTY;
          end
        end
      end
      K_FREE: begin
        // pool zero wins where ranges overlap
        p = holds(0, id) ? 0 : (holds(1, id) ? 1 : -1);
        if (p < 0) begin
          r.status = ST_FOREIGN;
        end else begin
          r.owned = 1'b1;
          if (rec_fill[p] >= POOL_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            rec_store[p][rec_tail[p]] = PTR_W'(id - base_q[p]);
            rec_tail[p] = rec_tail[p] + 1'b1;
            rec_fill[p] = rec_fill[p] + 1'b1;
          end
        end
      end
      K_QUERY: r.owned = holds(0, id) || holds(1, id);
      K_RESTART: rewind();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        base_q[p]  = '0;
        count_q[p] = '0;
      end
      rewind();
      replies_due.delete();
    end else begin
      // results first: a result never belongs to the item taken at this edge
      if (out_valid) begin
        got.id_result = out_id_result;
        got.owned     = out_owned;
        got.status    = status_t'(out_status);
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unrequested result id %h owned %b status %0d",
                     $time, got.id_result, got.owned, got.status);
        end else begin
          // oldest outstanding item
          want = replies_due[0];
          replies_due.delete(0);
          if (got.id_result !== want.id_result || got.owned !== want.owned ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: bad result: expected id %h owned %b status %0d,",
                        " got id %h owned %b status %0d"},
                       $time, want.id_result, want.owned, want.status,
                       got.id_result, got.owned, got.status);
          end
        end
      end

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_POOL0_BASE:  base_q[0]  = cfg_data;
          REG_POOL0_COUNT: count_q[0] = cfg_data[PCOUNT_W-1:0];
          REG_POOL1_BASE:  base_q[1]  = cfg_data;
          REG_POOL1_COUNT: count_q[1] = cfg_data[PCOUNT_W-1:0];
          default: ;
        endcase
      end

      if (start && !busy)
        replies_due.push_back(serve_request(in_kind, in_pool, in_id_value));
    end
    pending    <= replies_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import tpa_pkg::*;

  // Pool select codes on in_pool
  localparam logic [1:0] POOL_ZERO = 2'b00;
  localparam logic [1:0] POOL_ONE  = 2'b01;
  localparam logic [1:0] NO_POOL   = 2'b11;
  localparam logic [1:0] BAD_POOL  = 2'b10;

  localparam int ITEM_GOAL = 850;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CFG_IW-1:0]   cfg_index   = REG_POOL0_BASE;
  logic [CFG_DW-1:0]   cfg_data    = '0;
  logic                start       = 1'b0;
  logic [1:0]          in_kind     = K_ALLOC;
  logic signed [1:0]   in_pool     = '0;
  logic [ID_W-1:0]     in_id_value = '0;
  logic                busy;
  logic                out_valid;
  logic [ID_W-1:0]     out_id_result;
  logic                out_owned;
  logic [1:0]          out_status;
  int                  fail_count;
  int                  pending;

  // Ranges as programmed, used to aim ids near the pools
  logic [ID_W-1:0] cur_base [POOL_COUNT];
  int              cur_size [POOL_COUNT];
  int              items_sent = 0;
  bit              steady = 1'b0;

  always #4 clk = ~clk;

  two_pool_id_free_list_allocator_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_kind(in_kind), .in_pool(in_pool), .in_id_value(in_id_value),
    .out_valid(out_valid), .out_id_result(out_id_result),
    .out_owned(out_owned), .out_status(out_status)
  );

  id_pool_monitor monitor (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_kind(in_kind), .in_pool(in_pool), .in_id_value(in_id_value),
    .out_valid(out_valid), .out_id_result(out_id_result),
    .out_owned(out_owned), .out_status(out_status),
    .fail_count(fail_count), .pending(pending)
  );

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(kind_t k, logic [1:0] p, logic [ID_W-1:0] id);
    int gap;
    in_kind     <= k;
    in_pool     <= p;
    in_id_value <= id;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every item has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_pools(logic [CFG_DW-1:0] b0, logic [CFG_DW-1:0] c0,
                               logic [CFG_DW-1:0] b1, logic [CFG_DW-1:0] c1);
    put_reg(REG_POOL0_BASE, b0);
    put_reg(REG_POOL0_COUNT, c0);
    put_reg(REG_POOL1_BASE, b1);
    put_reg(REG_POOL1_COUNT, c1);
    cfg_we      <= 1'b0;
    cur_base[0] = b0;
    cur_base[1] = b1;
    cur_size[0] = (c0[PCOUNT_W-1:0] > POOL_DEPTH) ? POOL_DEPTH : int'(c0[PCOUNT_W-1:0]);
    cur_size[1] = (c1[PCOUNT_W-1:0] > POOL_DEPTH) ? POOL_DEPTH : int'(c1[PCOUNT_W-1:0]);
  endtask

  function automatic logic [1:0] pick_pool();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return NO_POOL;
    if (r < 9) return BAD_POOL;
    return $urandom_range(0, 1) ? POOL_ONE : POOL_ZERO;
  endfunction

  // Ids mostly just inside or just past a pool range
  function automatic logic [ID_W-1:0] aim_id();
    int r;
    int p;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 1);
    if (r < 12) return ID_W'($urandom);
    if (r < 16) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (r < 22) return cur_base[p] - 1'b1;
    return cur_base[p] + ID_W'($urandom_range(0, cur_size[p]));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'd65279;
    if (r == 2) return 16'hFFF0 + CFG_DW'($urandom_range(0, 15));
    return CFG_DW'($urandom);
  endfunction

  function automatic logic [CFG_DW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'd0;
    if (r < 40) return CFG_DW'($urandom_range(1, 3));
    if (r < 75) return CFG_DW'($urandom_range(4, 12));
    if (r < 85) return 16'd256;
    if (r < 90) return 16'h01FF;
    if (r < 95) return CFG_DW'($urandom);
    return CFG_DW'($urandom_range(13, 255));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 46)      send_item(K_ALLOC, pick_pool(), ID_W'($urandom));
    else if (r < 80) send_item(K_FREE, pick_pool(), aim_id());
    else if (r < 96) send_item(K_QUERY, pick_pool(), aim_id());
    else             send_item(K_RESTART, pick_pool(), ID_W'($urandom));
  endtask

  initial begin : stimulus
    logic [CFG_DW-1:0] b0;
    int                sel;
    int                n;
    cur_base[0] = '0;
    cur_base[1] = '0;
    cur_size[0] = 0;
    cur_size[1] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: both pools empty
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ONE, 16'h0000);
    send_item(K_ALLOC, NO_POOL, 16'hFFFF);
    send_item(K_FREE, POOL_ZERO, 16'h0000);
    send_item(K_QUERY, POOL_ZERO, 16'hFFFF);
    drain();

    // Top base with full count, oversized count on pool one
    program_pools(16'd65279, 16'd256, 16'h0000, 16'h01FF);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ONE, 16'h0000);
    send_item(K_ALLOC, BAD_POOL, 16'h0000);
    send_item(K_QUERY, POOL_ZERO, 16'hFFFE);
    send_item(K_QUERY, POOL_ZERO, 16'hFFFF);
    send_item(K_FREE, POOL_ZERO, 16'd65279);
    send_item(K_FREE, POOL_ZERO, 16'hFFFF);
    send_item(K_FREE, POOL_ONE, 16'h0000);
    send_item(K_QUERY, POOL_ONE, 16'h0100);
    send_item(K_RESTART, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    drain();

    // Overlapping one-entry pools: pool zero takes the free, then reuse
    program_pools(16'h1000, 16'd1, 16'h1000, 16'd1);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_FREE, POOL_ONE, 16'h1000);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ONE, 16'h0000);
    send_item(K_ALLOC, POOL_ONE, 16'h0000);
    drain();

    // Identifier wraps past the top of the id space
    program_pools(16'hFFFF, 16'd2, 16'h0000, 16'd0);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_ALLOC, POOL_ZERO, 16'h0000);
    send_item(K_QUERY, POOL_ZERO, 16'hFFFF);
    drain();

    // Flood one free list past full with repeated frees, then keep using it
    sel = $urandom_range(0, 1);
    b0  = pick_base();
    program_pools(b0, 16'd2, b0 ^ 16'h8000, 16'd3);
    steady = $urandom_range(0, 1);
    repeat (POOL_DEPTH + 3)
      send_item(K_FREE, pick_pool(),
                cur_base[sel] + ID_W'($urandom_range(0, cur_size[sel] - 1)));
    steady = 1'b0;
    repeat (20) random_item();
    drain();

    // Random phases, each with a fresh pool setup
    while (items_sent < ITEM_GOAL) begin
      b0 = pick_base();
      program_pools(b0, pick_count(),
                    ($urandom_range(0, 4) == 0) ? b0 + CFG_DW'($urandom_range(0, 6))
                                                 : pick_base(),
                    pick_count());
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) send_item(K_RESTART, pick_pool(), ID_W'($urandom));
      n = $urandom_range(15, 60);
      repeat (n) random_item();
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
